>>> rtl/best_fit_space_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit space allocator
// Shared implication forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_SPACE_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SPACE_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define BFSA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfsa same-cycle check failed");

// Next-cycle implication
`define BFSA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfsa next-cycle check failed");

`endif

>>> rtl/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// Types and codes shared by the best-fit space allocator files.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FROM_TABLE = 3'd0,
    ST_FROM_TOP   = 3'd1,
    ST_FREED      = 3'd2,
    ST_TOP_LOWER  = 3'd3,
    ST_DROPPED    = 3'd4,
    ST_EXHAUSTED  = 3'd5
  } status_t;

  // Operation codes
  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_MERGE,
    FSM_UPDATE,
    FSM_DONE
  } fsm_t;

  // One free-extent table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] stamp;
  } entry_t;

endpackage

>>> rtl/bfsa_ifs.sv
// ----------------------------------------------------------------------------
// bfsa channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfsa_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] blk_offset;
  logic [31:0] req_size;

  modport source (output valid, opcode, blk_offset, req_size, input ready);
  modport sink   (input valid, opcode, blk_offset, req_size, output ready);
endinterface

interface bfsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_offset;
  logic [2:0]  status;

  modport source (output valid, out_offset, status, input ready);
  modport sink   (input valid, out_offset, status, output ready);
endinterface

>>> rtl/best_fit_space_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_space_allocator
// Best-fit free-extent allocator with single-neighbor coalescing.
// ----------------------------------------------------------------------------
// The block takes one word at a time. The scan reads every table entry
// through the single RAM read port, one entry a cycle, and a shared compare
// unit keeps the running best fit, neighbor matches and first free slot.
// A drain, a merge and an update step follow, and then a done step loads
// the output register. A finished result sits in the output register while
// the next word is accepted. If the receiver has not taken that result when
// the next word is done, the block waits in its final step, and input stays
// blocked until the output register is free. Valid bits clear at reset, so
// no clearing pass is needed.
module best_fit_space_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  bfsa_in_if.sink        in_ch,
  bfsa_out_if.source     out_ch
);

  `include "best_fit_space_allocator_macros.svh"

  localparam int AW = $clog2(TABLE_DEPTH);

  bfsa_pkg::fsm_t   state, state_next;
  logic [AW-1:0]    cnt;
  logic             chk_en;
  logic [AW-1:0]    chk_idx;
  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0]      top;
  logic [31:0]      stamp_cnt;

  // latched request
  logic             op;
  logic [31:0]      off;
  logic [31:0]      size;
  logic [31:0]      end_r;

  // scan results
  logic             best_f;
  logic [AW-1:0]    best_idx;
  logic [31:0]      best_start, best_len, best_age;
  logic             n1_f, n2_f, free_f;
  logic [AW-1:0]    n1_idx, n2_idx, free_idx;
  logic [31:0]      n1_start, n1_len, n2_start, n2_len;

  // merge results
  logic             m_found;
  logic [AW-1:0]    m_slot;
  logic [31:0]      m_start, m_len;
  logic [31:0]      rem_start, rem_len;
  logic             rem_nz, fits_top;

  // output register
  logic             out_valid;
  logic [31:0]      res_off, out_off;
  bfsa_pkg::status_t res_st, out_st;

  // result of the update step, kept until DONE
  bfsa_pkg::status_t hold_st;
  logic [31:0]       hold_off;
  logic              ld_out;

  // RAM ports
  logic             we;
  logic [AW-1:0]    waddr;
  bfsa_pkg::entry_t wdata, rdata;

  logic             acc;
  logic [31:0]      age;
  logic [31:0]      m_end;

  bfsa_ram #(.WIDTH($bits(bfsa_pkg::entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rdata)
  );

  assign in_ch.ready       = (state == bfsa_pkg::FSM_IDLE);
  assign acc               = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.out_offset = out_off;
  assign out_ch.status     = out_st;
  assign age               = stamp_cnt - rdata.stamp;
  assign m_end             = m_start + m_len;
  assign ld_out            = (state == bfsa_pkg::FSM_DONE) && (!out_valid || out_ch.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfsa_pkg::FSM_IDLE:   if (acc) state_next = bfsa_pkg::FSM_SCAN;
      bfsa_pkg::FSM_SCAN:   if (cnt == AW'(TABLE_DEPTH - 1)) state_next = bfsa_pkg::FSM_DRAIN;
      bfsa_pkg::FSM_DRAIN:  state_next = bfsa_pkg::FSM_MERGE;
      bfsa_pkg::FSM_MERGE:  state_next = bfsa_pkg::FSM_UPDATE;
      bfsa_pkg::FSM_UPDATE: state_next = bfsa_pkg::FSM_DONE;
      bfsa_pkg::FSM_DONE:   if (!out_valid || out_ch.ready) state_next = bfsa_pkg::FSM_IDLE;
      default:              state_next = bfsa_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfsa_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // update decision: table write, top move, result
  always_comb begin
    we     = 1'b0;
    waddr  = best_idx;
    wdata  = '{start: rem_start, length: rem_len, stamp: stamp_cnt};
    res_off = '0;
    res_st  = bfsa_pkg::ST_FROM_TABLE;
    if (op == bfsa_pkg::OP_ALLOC) begin
      if (best_f) begin
        res_off = best_start;
        we      = rem_nz;
      end else if (fits_top) begin
        res_off = top;
        res_st  = bfsa_pkg::ST_FROM_TOP;
      end else begin
        res_st  = bfsa_pkg::ST_EXHAUSTED;
      end
    end else begin
      wdata = '{start: m_start, length: m_len, stamp: stamp_cnt};
      if (m_end == top) begin
        res_st = bfsa_pkg::ST_TOP_LOWER;
      end else if (m_found) begin
        we     = 1'b1;
        waddr  = m_slot;
        res_st = bfsa_pkg::ST_FREED;
      end else if (free_f) begin
        we     = 1'b1;
        waddr  = free_idx;
        res_st = bfsa_pkg::ST_FREED;
      end else begin
        res_st = bfsa_pkg::ST_DROPPED;
      end
    end
    if (state != bfsa_pkg::FSM_UPDATE) begin
      we = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      chk_en    <= 1'b0;
      valid     <= '0;
      top       <= '0;
      stamp_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      chk_en <= (state == bfsa_pkg::FSM_SCAN);
      if (state == bfsa_pkg::FSM_SCAN) begin
        cnt <= (cnt == AW'(TABLE_DEPTH - 1)) ? '0 : cnt + 1'b1;
      end
      if (state == bfsa_pkg::FSM_UPDATE) begin
        if (we) begin
          valid[waddr] <= 1'b1;
          stamp_cnt    <= stamp_cnt + 32'd1;
        end
        if (op == bfsa_pkg::OP_ALLOC) begin
          if (best_f && !rem_nz) begin
            valid[best_idx] <= 1'b0;
          end else if (!best_f && fits_top) begin
            top <= top + size;
          end
        end else if (m_end == top) begin
          top <= top - m_len;
          if (m_found) begin
            valid[m_slot] <= 1'b0;
          end
        end
      end
      if (state == bfsa_pkg::FSM_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: request, scan, merge, result
  always_ff @(posedge clk) begin
    chk_idx <= cnt;
    if (acc) begin
      op     <= in_ch.opcode;
      off    <= in_ch.blk_offset;
      size   <= in_ch.req_size;
      end_r  <= in_ch.blk_offset + in_ch.req_size;
      best_f <= 1'b0;
      n1_f   <= 1'b0;
      n2_f   <= 1'b0;
      free_f <= 1'b0;
    end
    // one entry per cycle through the compare unit
    if (chk_en) begin
      if (op == bfsa_pkg::OP_ALLOC) begin
        if (valid[chk_idx] && rdata.length >= size &&
            (!best_f || rdata.length < best_len ||
             (rdata.length == best_len && age > best_age))) begin
          best_f     <= 1'b1;
          best_idx   <= chk_idx;
          best_start <= rdata.start;
          best_len   <= rdata.length;
          best_age   <= age;
        end
      end else begin
        if (valid[chk_idx] && !n1_f && rdata.start == end_r) begin
          n1_f     <= 1'b1;
          n1_idx   <= chk_idx;
          n1_start <= rdata.start;
          n1_len   <= rdata.length;
        end
        if (valid[chk_idx] && !n2_f && (rdata.start + rdata.length) == off) begin
          n2_f     <= 1'b1;
          n2_idx   <= chk_idx;
          n2_start <= rdata.start;
          n2_len   <= rdata.length;
        end
      end
      if (!valid[chk_idx] && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= chk_idx;
      end
    end
    // merge step
    if (state == bfsa_pkg::FSM_MERGE) begin
      rem_start <= best_start + size;
      rem_len   <= best_len - size;
      rem_nz    <= best_len > size;
      fits_top  <= size <= ~top;
      m_found   <= n1_f || n2_f;
      if (n1_f) begin
        m_slot  <= n1_idx;
        m_len   <= n1_len + size;
        m_start <= (n1_start > off) ? off : n1_start;
      end else if (n2_f) begin
        m_slot  <= n2_idx;
        m_len   <= n2_len + size;
        m_start <= (n2_start > off) ? off : n2_start;
      end else begin
        m_slot  <= free_idx;
        m_len   <= size;
        m_start <= off;
      end
    end
    // top and table have moved by DONE, so the held result is loaded
    if (state == bfsa_pkg::FSM_DONE && (!out_valid || out_ch.ready)) begin
      out_off <= hold_off;
      out_st  <= hold_st;
    end
  end

  // keep result of the update step until DONE
  always_ff @(posedge clk) begin
    if (state == bfsa_pkg::FSM_UPDATE) begin
      hold_st  <= res_st;
      hold_off <= res_off;
    end
  end

  // checks
  `BFSA_ASSERT_NXT(a_acc_scan, clk, rst, acc, state == bfsa_pkg::FSM_SCAN)
  `BFSA_ASSERT_IMP(a_we_upd, clk, rst, we, state == bfsa_pkg::FSM_UPDATE)
  `BFSA_ASSERT_NXT(a_top_stable, clk, rst, state != bfsa_pkg::FSM_UPDATE, $stable(top))
  `BFSA_ASSERT_NXT(a_res_load, clk, rst, ld_out, out_valid && out_st == hold_st && out_off == hold_off)

endmodule

>>> rtl/bfsa_ram.sv
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/tb_best_fit_space_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit space allocator testbench
// Sends directed and random allocate/release words and compares every result
// with a built-in model of the extent table and the top pointer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_best_fit_space_allocator;

  localparam int DEPTH      = 64;
  localparam int LATENCY    = DEPTH + 10;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 1080;

  logic clk;
  logic rst;

  bfsa_in_if  in_ch ();
  bfsa_out_if out_ch ();

  best_fit_space_allocator #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct packed {
    logic [31:0]       offset;
    bfsa_pkg::status_t status;
  } grant_t;

  // Model state
  logic [31:0] m_start  [DEPTH];
  logic [31:0] m_length [DEPTH];
  logic        m_valid  [DEPTH];
  logic [31:0] m_stamp  [DEPTH];
  logic [31:0] m_counter;
  logic [31:0] m_top;

  grant_t pending_grants[$];
  int     errors;
  int     n_sent;
  int     n_checked;
  int     n_status[6];
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_recv;
  bit     done;
  int     quiet_cycles;

  // Live extents, used to pick realistic release targets
  logic [31:0] live_off[$];
  logic [31:0] live_len[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void model_clear();
    for (int i = 0; i < DEPTH; i++) begin
      m_start[i]  = '0;
      m_length[i] = '0;
      m_valid[i]  = 1'b0;
      m_stamp[i]  = '0;
    end
    m_counter = '0;
    m_top     = '0;
  endfunction

  function automatic void model_put(int slot, logic [31:0] s, logic [31:0] l);
    m_start[slot]  = s;
    m_length[slot] = l;
    m_valid[slot]  = 1'b1;
    m_stamp[slot]  = m_counter;
    m_counter      = m_counter + 32'd1;
  endfunction

  // Predict the result of one word and advance the model
  function automatic grant_t predict_grant(bfsa_pkg::opcode_t op, logic [31:0] off,
                                           logic [31:0] size);
    grant_t      g;
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    logic [31:0] fend;
    logic [31:0] nstart;
    logic [31:0] nlen;
    int          slot;
    g.offset = '0;
    best     = -1;
    best_age = '0;
    slot     = -1;
    if (op == bfsa_pkg::OP_ALLOC) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (m_valid[i] && m_length[i] >= size) begin
          age = m_counter - m_stamp[i];
          if (best < 0 || m_length[i] < m_length[best] ||
              (m_length[i] == m_length[best] && age > best_age)) begin
            best     = i;
            best_age = age;
          end
        end
      end
      if (best >= 0) begin
        g.offset = m_start[best];
        if (m_length[best] > size) begin
          model_put(best, m_start[best] + size, m_length[best] - size);
        end else begin
          m_valid[best] = 1'b0;
        end
        g.status = bfsa_pkg::ST_FROM_TABLE;
      end else if (size > 32'hFFFF_FFFF - m_top) begin
        g.status = bfsa_pkg::ST_EXHAUSTED;
      end else begin
        g.offset = m_top;
        m_top    = m_top + size;
        g.status = bfsa_pkg::ST_FROM_TOP;
      end
    end else begin
      fend   = off + size;
      nstart = off;
      nlen   = size;
      for (int i = 0; i < DEPTH && slot < 0; i++)
        if (m_valid[i] && m_start[i] == fend) slot = i;
      for (int i = 0; i < DEPTH && slot < 0; i++)
        if (m_valid[i] && m_start[i] + m_length[i] == off) slot = i;
      if (slot >= 0) begin
        nlen          = m_length[slot] + size;
        nstart        = (m_start[slot] > off) ? off : m_start[slot];
        m_valid[slot] = 1'b0;
      end
      if (nstart + nlen == m_top) begin
        m_top    = m_top - nlen;
        g.status = bfsa_pkg::ST_TOP_LOWER;
      end else begin
        if (slot < 0)
          for (int i = 0; i < DEPTH && slot < 0; i++)
            if (!m_valid[i]) slot = i;
        if (slot < 0) begin
          g.status = bfsa_pkg::ST_DROPPED;
        end else begin
          model_put(slot, nstart, nlen);
          g.status = bfsa_pkg::ST_FREED;
        end
      end
    end
    return g;
  endfunction

  // Send one word; queue the expectation when it is accepted.
  // valid stays high after acceptance until the next word or an idle cycle.
  task automatic send_word(bfsa_pkg::opcode_t op, logic [31:0] off, logic [31:0] size,
                           bit has_exp, grant_t exp_g);
    grant_t g;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.blk_offset <= off;
    in_ch.req_size   <= size;
    do @(posedge clk); while (!in_ch.ready);
    g = predict_grant(op, off, size);
    if (has_exp && g != exp_g) begin
      $display("%0t table row mismatch: expected off=%h st=%0d, model off=%h st=%0d",
               $time, exp_g.offset, exp_g.status, g.offset, g.status);
      errors++;
    end
    pending_grants.push_back(g);
    n_sent++;
    if (op == bfsa_pkg::OP_ALLOC &&
        (g.status == bfsa_pkg::ST_FROM_TABLE || g.status == bfsa_pkg::ST_FROM_TOP)
        && size != 0 && live_off.size() < 200) begin
      live_off.push_back(g.offset);
      live_len.push_back(size);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // Random word: mostly releases of live extents and modest allocations
  task automatic send_random();
    int          k;
    int          pick;
    logic [31:0] off;
    logic [31:0] size;
    pick = $urandom_range(99);
    if (pick < 40 && live_off.size() > 0) begin
      k    = $urandom_range(live_off.size() - 1);
      off  = live_off[k];
      size = live_len[k];
      live_off.delete(k);
      live_len.delete(k);
      send_word(bfsa_pkg::OP_RELEASE, off, size, 1'b0, '0);
    end else if (pick < 80) begin
      send_word(bfsa_pkg::OP_ALLOC, '0, $urandom_range(1, 64), 1'b0, '0);
    end else if (pick < 88) begin
      send_word(bfsa_pkg::OP_ALLOC, $urandom(),
                ($urandom_range(3) == 0) ? $urandom() : 32'd0, 1'b0, '0);
    end else begin
      send_word(bfsa_pkg::OP_RELEASE, $urandom(), $urandom(), 1'b0, '0);
    end
  endtask

  // Receiver: random stall plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_recv && !(recv_idle_pct > 0 &&
                      $urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected word: off=%h st=%0d", $time, out_ch.out_offset,
                 out_ch.status);
        errors++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (out_ch.out_offset !== exp_g.offset) begin
          $display("%0t out_offset mismatch: expected %h, actual %h", $time,
                   exp_g.offset, out_ch.out_offset);
          errors++;
        end
        if (out_ch.status !== exp_g.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d", $time,
                   exp_g.status, out_ch.status);
          errors++;
        end
        n_status[exp_g.status]++;
        n_checked++;
      end
    end
  end

  // Watchdog: cycles with no accepted word on either side
  always @(posedge clk) begin
    if (rst || done || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", pending_grants.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  typedef struct {
    bfsa_pkg::opcode_t op;
    logic [31:0]       off;
    logic [31:0]       size;
    bit                has_exp;
    grant_t            exp_g;
  } row_t;

  row_t rows[$];

  initial begin
    int hold;
    errors        = 0;
    n_sent        = 0;
    n_checked     = 0;
    done          = 1'b0;
    hold_recv     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles  = 0;
    foreach (n_status[i]) n_status[i] = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = bfsa_pkg::OP_ALLOC;
    in_ch.blk_offset = '0;
    in_ch.req_size   = '0;
    out_ch.ready     = 1'b0;
    model_clear();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: zero alloc on empty, top grants, merges, wrap, odd frees
    rows = '{
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h0,         1, '{32'h0,  bfsa_pkg::ST_FROM_TOP}},
      '{bfsa_pkg::OP_ALLOC,   32'hFFFF_FFFF, 32'h10,        1, '{32'h0,  bfsa_pkg::ST_FROM_TOP}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h20,        1, '{32'h10, bfsa_pkg::ST_FROM_TOP}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'hFFFF_FFFF, 1,
        '{32'h0, bfsa_pkg::ST_EXHAUSTED}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h8,         1, '{32'h30, bfsa_pkg::ST_FROM_TOP}},
      '{bfsa_pkg::OP_RELEASE, 32'h30,        32'h8,         1,
        '{32'h0, bfsa_pkg::ST_TOP_LOWER}},
      '{bfsa_pkg::OP_RELEASE, 32'h0,         32'h10,        1, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h0,         0,
        '{32'h0, bfsa_pkg::ST_FROM_TABLE}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h4,         0,
        '{32'h0, bfsa_pkg::ST_FROM_TABLE}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'hC,         0,
        '{32'h0, bfsa_pkg::ST_FROM_TABLE}},
      '{bfsa_pkg::OP_RELEASE, 32'h0,         32'h4,         0, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_RELEASE, 32'h4,         32'h4,         0, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_RELEASE, 32'h8,         32'h8,         0, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_RELEASE, 32'h10,        32'h20,        0,
        '{32'h0, bfsa_pkg::ST_TOP_LOWER}},
      '{bfsa_pkg::OP_RELEASE, 32'hFFFF_FFF0, 32'h20,        0, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_RELEASE, 32'h1000,      32'h0,         0, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h0,         0,
        '{32'h0, bfsa_pkg::ST_FROM_TABLE}},
      '{bfsa_pkg::OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '{32'h0,  bfsa_pkg::ST_FREED}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'h7FFF_FFFF, 0,
        '{32'h0, bfsa_pkg::ST_FROM_TABLE}},
      '{bfsa_pkg::OP_ALLOC,   32'h0,         32'hFFFF_FFFF, 0,
        '{32'h0, bfsa_pkg::ST_FROM_TABLE}}
    };
    foreach (rows[i])
      send_word(rows[i].op, rows[i].off, rows[i].size, rows[i].has_exp, rows[i].exp_g);
    wait_drained();
    live_off.delete();
    live_len.delete();

    // Fill the table with scattered frees far above the top so it overflows
    for (int i = 0; i < DEPTH + 6; i++)
      send_word(bfsa_pkg::OP_RELEASE, 32'h4000_0000 + i * 32'h100, 32'h10, 1'b0, '0);

    // Long receiver hold-off while words keep coming
    hold_recv <= 1'b1;
    fork
      begin
        for (hold = 0; hold < 3 * LATENCY; hold++) @(posedge clk);
        hold_recv <= 1'b0;
      end
      for (int i = 0; i < 4; i++) send_word(bfsa_pkg::OP_ALLOC, '0, 32'h10, 1'b0, '0);
    join
    wait_drained();

    // Random phases with different stall mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 27 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) send_random();
      wait_drained();
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    done = 1'b1;
    $display("Ran %0d words, checked %0d results; status counts 0..5: %0d %0d %0d %0d %0d %0d",
             n_sent, n_checked, n_status[0], n_status[1], n_status[2], n_status[3],
             n_status[4], n_status[5]);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bfsa_pkg.sv
rtl/bfsa_ifs.sv
rtl/bfsa_ram.sv
rtl/best_fit_space_allocator.sv
tb/tb_best_fit_space_allocator.sv
